/* rtl/ilu_pkg.sv */
// Shared types, character codes and helper functions of the integer literal parser.
// No dependencies; every module file of the block imports this package.
`default_nettype none

package ilu_pkg;

	typedef enum logic [1:0] {
		RADIX_DEC = 2'd0,
		RADIX_HEX = 2'd1,
		RADIX_BIN = 2'd2
	} radix_t;

	typedef enum logic [3:0] {
		SFX_EMPTY = 4'd0,
		SFX_LEAD  = 4'd1,
		SFX_ONE   = 4'd2,
		SFX_THREE = 4'd3,
		SFX_SIX   = 4'd4,
		SFX_S     = 4'd5,
		SFX_SI    = 4'd6,
		SFX_SIZ   = 4'd7,
		SFX_ACC   = 4'd8,
		SFX_DEAD  = 4'd9
	} sfx_state_t;

	typedef enum logic [1:0] {
		TOK_SKIP  = 2'd0,
		TOK_DIGIT = 2'd1,
		TOK_BAD   = 2'd2
	} tok_kind_t;

	// One classified character, handed from the front end to the accumulator.
	typedef struct packed {
		tok_kind_t  kind;
		logic [3:0] digit;
		radix_t     radix;
		logic       last;
		logic       sfx_ok;
	} token_t;

	localparam logic [7:0] CH_0       = "0";
	localparam logic [7:0] CH_9       = "9";
	localparam logic [7:0] CH_LA      = "a";
	localparam logic [7:0] CH_LF      = "f";
	localparam logic [7:0] CH_UA      = "A";
	localparam logic [7:0] CH_UF      = "F";
	localparam logic [7:0] CH_UNDER   = "_";
	localparam logic [7:0] CH_LX      = "x";
	localparam logic [7:0] CH_UX      = "X";
	localparam logic [7:0] CH_LB      = "b";
	localparam logic [7:0] CH_UB      = "B";
	localparam logic [7:0] CH_I       = "i";
	localparam logic [7:0] CH_U       = "u";
	localparam logic [7:0] CH_1       = "1";
	localparam logic [7:0] CH_2       = "2";
	localparam logic [7:0] CH_3       = "3";
	localparam logic [7:0] CH_4       = "4";
	localparam logic [7:0] CH_6       = "6";
	localparam logic [7:0] CH_8       = "8";
	localparam logic [7:0] CH_S       = "s";
	localparam logic [7:0] CH_Z       = "z";
	localparam logic [7:0] CH_E       = "e";
	localparam logic [4:0] NOT_DIGIT  = 5'd16;

	// Digit value 0..15, or NOT_DIGIT for any other character.
	function automatic logic [4:0] digit_of(input logic [7:0] c);
		logic [4:0] d;
		d = NOT_DIGIT;
		if (c inside {[CH_0:CH_9]}) begin
			d = 5'(c - CH_0);
		end else if (c inside {[CH_LA:CH_LF]}) begin
			d = 5'(c - CH_LA) + 5'd10;
		end else if (c inside {[CH_UA:CH_UF]}) begin
			d = 5'(c - CH_UA) + 5'd10;
		end
		return d;
	endfunction

	function automatic sfx_state_t sfx_next(input sfx_state_t st, input logic [7:0] c);
		sfx_state_t n;
		n = SFX_DEAD;
		case (st)
			SFX_EMPTY: begin
				if (c == CH_I || c == CH_U) n = SFX_LEAD;
			end
			SFX_LEAD: begin
				if (c == CH_8) n = SFX_ACC;
				else if (c == CH_1) n = SFX_ONE;
				else if (c == CH_3) n = SFX_THREE;
				else if (c == CH_6) n = SFX_SIX;
				else if (c == CH_S) n = SFX_S;
			end
			SFX_ONE: begin
				if (c == CH_6) n = SFX_ACC;
			end
			SFX_THREE: begin
				if (c == CH_2) n = SFX_ACC;
			end
			SFX_SIX: begin
				if (c == CH_4) n = SFX_ACC;
			end
			SFX_S: begin
				if (c == CH_I) n = SFX_SI;
			end
			SFX_SI: begin
				if (c == CH_Z) n = SFX_SIZ;
			end
			SFX_SIZ: begin
				if (c == CH_E) n = SFX_ACC;
			end
			default: begin
				n = SFX_DEAD;
			end
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

/* rtl/ilu_ifs.sv */
// Valid/ready channel interfaces of the integer literal parser: characters in, results out.
// No dependencies.
`default_nettype none

interface ilu_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       is_last;

	modport source (output valid, output char_code, output is_last, input ready);
	modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface ilu_res_if;
	logic        valid;
	logic        ready;
	logic        ok;
	logic [63:0] number;

	modport source (output valid, output ok, output number, input ready);
	modport sink   (input valid, input ok, input number, output ready);
endinterface

`default_nettype wire

/* rtl/ilu_front.sv */
// Front end: accepts characters, tracks prefix, radix and suffix state, emits tokens.
// Depends on ilu_pkg and ilu_char_if.
`default_nettype none

module ilu_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	ilu_char_if.sink            chars,
	output logic                tok_valid,
	input  wire logic           tok_ready,
	output ilu_pkg::token_t     tok
);
	import ilu_pkg::*;

	logic [1:0]  pos_q;
	logic        prefix_q;
	radix_t      radix_q;
	logic        in_sfx_q;
	sfx_state_t  sfx_q;

	logic [7:0]  c;
	logic [4:0]  d;
	logic        is_x;
	logic        is_b;
	logic        handled;
	logic        too_big;
	logic        accept;
	radix_t      radix_n;
	logic        in_sfx_n;
	sfx_state_t  sfx_n;
	tok_kind_t   kind;

	assign c      = chars.char_code;
	assign accept = chars.valid && tok_ready;

	assign chars.ready = tok_ready;
	assign tok_valid   = chars.valid;

	always_comb begin
		d       = digit_of(c);
		is_x    = (c == CH_LX) || (c == CH_UX);
		is_b    = (c == CH_LB) || (c == CH_UB);
		// The prefix only counts when the first character was zero and more text follows.
		handled = (pos_q == 2'd1) && prefix_q && !chars.is_last && (is_x || is_b);
		case (radix_q)
			RADIX_HEX: too_big = 1'b0;
			RADIX_BIN: too_big = (d[3:0] > 4'd1);
			default:   too_big = (d[3:0] > 4'd9);
		endcase
		radix_n  = radix_q;
		in_sfx_n = in_sfx_q;
		sfx_n    = sfx_q;
		kind     = TOK_SKIP;
		if (handled) begin
			radix_n = is_x ? RADIX_HEX : RADIX_BIN;
		end else if (in_sfx_q) begin
			sfx_n = sfx_next(sfx_q, c);
		end else if (c != CH_UNDER) begin
			if (d[4]) begin
				in_sfx_n = 1'b1;
				sfx_n    = sfx_next(SFX_EMPTY, c);
			end else if (too_big) begin
				kind = TOK_BAD;
			end else begin
				kind = TOK_DIGIT;
			end
		end
	end

	always_comb begin
		tok.kind   = kind;
		tok.digit  = d[3:0];
		tok.radix  = radix_q;
		tok.last   = chars.is_last;
		tok.sfx_ok = (sfx_n == SFX_EMPTY) || (sfx_n == SFX_ACC);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 2'd0;
			prefix_q <= 1'b0;
			radix_q  <= RADIX_DEC;
			in_sfx_q <= 1'b0;
			sfx_q    <= SFX_EMPTY;
		end else if (accept) begin
			if (chars.is_last) begin
				pos_q    <= 2'd0;
				prefix_q <= 1'b0;
				radix_q  <= RADIX_DEC;
				in_sfx_q <= 1'b0;
				sfx_q    <= SFX_EMPTY;
			end else begin
				pos_q    <= (pos_q == 2'd2) ? 2'd2 : pos_q + 2'd1;
				prefix_q <= (pos_q == 2'd0) && (c == CH_0);
				radix_q  <= radix_n;
				in_sfx_q <= in_sfx_n;
				sfx_q    <= sfx_n;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/ilu_queue.sv */
// Small token queue between the front end and the accumulator.
// Depends on ilu_pkg.
`default_nettype none

module ilu_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_valid,
	output logic                   wr_ready,
	input  wire ilu_pkg::token_t   wr_data,
	output logic                   rd_valid,
	input  wire logic              rd_ready,
	output ilu_pkg::token_t        rd_data
);
	import ilu_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL      = CW'(DEPTH);

	token_t         mem_q [DEPTH];
	logic [AW-1:0]  wptr_q;
	logic [AW-1:0]  rptr_q;
	logic [CW-1:0]  count_q;
	logic           push;
	logic           pop;

	assign wr_ready = (count_q != FULL);
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == LAST_SLOT) ? '0 : wptr_q + AW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == LAST_SLOT) ? '0 : rptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/ilu_back.sv */
// Back end: shift-add accumulation with overflow check, and the result register.
// Depends on ilu_pkg and ilu_res_if.
`default_nettype none

module ilu_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              tok_valid,
	output logic                   tok_ready,
	input  wire ilu_pkg::token_t   tok,
	ilu_res_if.source              result
);
	import ilu_pkg::*;

	logic [63:0] acc_q;
	logic        err_q;
	logic        res_valid_q;
	logic        res_ok_q;
	logic [63:0] res_num_q;

	logic [67:0] prod;
	logic [67:0] sum;
	logic        ovf;
	logic        take;
	logic [63:0] acc_n;
	logic        err_n;
	logic        ok_n;

	// Only a closing token needs room in the result register.
	assign tok_ready = !tok.last || !res_valid_q || result.ready;
	assign take      = tok_valid && tok_ready;

	always_comb begin
		case (tok.radix)
			RADIX_HEX: prod = {acc_q, 4'b0};
			RADIX_BIN: prod = {3'b0, acc_q, 1'b0};
			default:   prod = {1'b0, acc_q, 3'b0} + {3'b0, acc_q, 1'b0};
		endcase
		sum   = prod + {64'b0, tok.digit};
		ovf   = |sum[67:64];
		acc_n = acc_q;
		err_n = err_q;
		if (tok.kind == TOK_BAD) begin
			err_n = 1'b1;
		end else if (tok.kind == TOK_DIGIT) begin
			if (ovf) begin
				err_n = 1'b1;
			end else begin
				acc_n = sum[63:0];
			end
		end
		ok_n = !err_n && tok.sfx_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			err_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (take && tok.last) begin
				acc_q       <= '0;
				err_q       <= 1'b0;
				res_valid_q <= 1'b1;
			end else begin
				if (take) begin
					acc_q <= acc_n;
					err_q <= err_n;
				end
				if (result.ready) begin
					res_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && tok.last) begin
			res_ok_q  <= ok_n;
			res_num_q <= ok_n ? acc_n : 64'd0;
		end
	end

	assign result.valid  = res_valid_q;
	assign result.ok     = res_ok_q;
	assign result.number = res_num_q;

endmodule

`default_nettype wire

/* rtl/integer_literal_to_u64.sv */
// Top level of the integer literal parser: front end, token queue and accumulator.
// Depends on ilu_pkg, ilu_ifs, ilu_front, ilu_queue and ilu_back.
//
//   Channel   Dir  Payload              Transaction
//   chars     in   char_code, is_last   one character of a literal
//   result    out  ok, number           one parsed literal, after its last character
//
// One character is accepted every cycle while the token queue has room; the front end
// classifies it in the cycle it is accepted and the back end folds one token per cycle,
// unless a closing token waits on a held result. A result becomes valid once the
// closing token has passed the token queue into the result register, and is held until
// taken. A stalled result only blocks the closing token of the next literal; the queue
// then holds that token and at most QUEUE_DEPTH-1 characters behind it before the input
// stalls. Reset clears all control state; no clearing pass is needed.
`default_nettype none

module integer_literal_to_u64 #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ilu_char_if.sink   chars,
	ilu_res_if.source  result
);
	import ilu_pkg::*;

	logic   ftok_valid;
	logic   ftok_ready;
	token_t ftok;
	logic   btok_valid;
	logic   btok_ready;
	token_t btok;

	ilu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.chars     (chars),
		.tok_valid (ftok_valid),
		.tok_ready (ftok_ready),
		.tok       (ftok)
	);

	ilu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (ftok_valid),
		.wr_ready (ftok_ready),
		.wr_data  (ftok),
		.rd_valid (btok_valid),
		.rd_ready (btok_ready),
		.rd_data  (btok)
	);

	ilu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (btok_valid),
		.tok_ready (btok_ready),
		.tok       (btok),
		.result    (result)
	);

endmodule

`default_nettype wire
